[src/utf8v_pkg.sv]
package utf8v_pkg;

  // ascii bytes with rules of their own
  localparam logic [7:0] ByteDot       = 8'h2E;
  localparam logic [7:0] ByteSlash     = 8'h2F;
  localparam logic [7:0] ByteDel       = 8'h7F;
  localparam logic [7:0] ByteCtrlLimit = 8'h20;

  // codepoint limits
  localparam logic [20:0] CpMax       = 21'h10FFFF;
  localparam logic [20:0] CpSurrLo    = 21'h00D800;
  localparam logic [20:0] CpSurrHi    = 21'h00DFFF;
  localparam logic [20:0] CpMin2      = 21'h000080;
  localparam logic [20:0] CpMin3      = 21'h000800;
  localparam logic [20:0] CpMin4      = 21'h010000;
  localparam logic [20:0] CpC1Hi      = 21'h00009F;
  localparam logic [20:0] CpArabicMk  = 21'h00061C;
  localparam logic [20:0] CpRloOver   = 21'h00202E;
  localparam logic [20:0] CpBom       = 21'h00FEFF;
  localparam logic [20:0] CpTagHi     = 21'h0E007F;

  // number of continuation bytes of a sequence
  typedef logic [1:0] cont_cnt_t;

  // one input word as held in the input register
  typedef struct packed {
    logic [7:0] name_byte;
    logic       is_last;
  } name_word_t;

  // result handed from the decoder to the output register
  typedef struct packed {
    logic fire;
    logic name_valid;
  } verdict_t;

  // shortest-form floor for a sequence with len continuation bytes
  function automatic logic below_floor(logic [20:0] c, cont_cnt_t len);
    logic r;
    r = 1'b0;
    case (len)
      2'd1:    r = (c < CpMin2);
      2'd2:    r = (c < CpMin3);
      2'd3:    r = (c < CpMin4);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // controls, bidi marks and invisible codepoints
  function automatic logic cp_listed(logic [20:0] c);
    return c inside {[CpMin2:CpC1Hi], CpArabicMk,
                     [21'h00200E:21'h00200F], [21'h00202A:CpRloOver],
                     [21'h002066:21'h002069], 21'h0000AD, 21'h00034F,
                     21'h00180E, [21'h00200B:21'h00200D],
                     [21'h002028:21'h002029], [21'h002060:21'h002064],
                     [21'h00FE00:21'h00FE0F], CpBom,
                     [21'h00FFF9:21'h00FFFB], [21'h0E0000:CpTagHi]};
  endfunction

  // a finished multi-byte codepoint that fails a rule
  function automatic logic cp_bad(logic [20:0] c, cont_cnt_t len);
    return below_floor(c, len) || (c > CpMax) ||
           ((c >= CpSurrLo) && (c <= CpSurrHi)) || cp_listed(c);
  endfunction

endpackage

[src/utf8v_in_if.sv]
interface utf8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       is_last;

  modport source (output valid, output name_byte, output is_last, input ready);
  modport sink   (input valid, input name_byte, input is_last, output ready);
endinterface

[src/utf8v_out_if.sv]
interface utf8v_out_if;
  logic valid;
  logic ready;
  logic name_valid;

  modport source (output valid, output name_valid, input ready);
  modport sink   (input valid, input name_valid, output ready);
endinterface

[src/utf8v_in_stage.sv]
module utf8v_in_stage (
  input  logic                   clk,
  input  logic                   rst,
  utf8v_in_if.sink               name_in,
  input  logic                   advance,
  output logic                   word_valid,
  output utf8v_pkg::name_word_t  word
);
  import utf8v_pkg::*;

  logic load;

  // room when empty or when the held word moves on this cycle
  assign name_in.ready = !word_valid || advance;
  assign load          = name_in.valid && name_in.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (name_in.ready) begin
      word_valid <= name_in.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      word.name_byte <= name_in.name_byte;
      word.is_last   <= name_in.is_last;
    end
  end
endmodule

[src/utf8v_decode.sv]
module utf8v_decode (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   advance,
  input  utf8v_pkg::name_word_t  word,
  output utf8v_pkg::verdict_t    verdict
);
  import utf8v_pkg::*;

  logic        error_seen,      error_seen_next;
  cont_cnt_t   bytes_pending,   bytes_pending_next;
  cont_cnt_t   sequence_length, sequence_length_next;
  logic [20:0] codepoint_accum, codepoint_accum_next;
  logic        at_name_start;
  logic [7:0]  b;

  assign b = word.name_byte;

  // next decoder state for the held word
  always_comb begin
    error_seen_next      = error_seen;
    bytes_pending_next   = bytes_pending;
    sequence_length_next = sequence_length;
    codepoint_accum_next = codepoint_accum;
    if (!error_seen) begin
      if (bytes_pending == 2'd0) begin
        if ((at_name_start && b == ByteDot) || b == ByteSlash ||
            b < ByteCtrlLimit || b == ByteDel) begin
          error_seen_next = 1'b1;
        end else if (!b[7]) begin
          error_seen_next = 1'b0;
        end else if (b[7:5] == 3'b110) begin
          codepoint_accum_next = {16'd0, b[4:0]};
          sequence_length_next = 2'd1;
          bytes_pending_next   = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          codepoint_accum_next = {17'd0, b[3:0]};
          sequence_length_next = 2'd2;
          bytes_pending_next   = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          codepoint_accum_next = {18'd0, b[2:0]};
          sequence_length_next = 2'd3;
          bytes_pending_next   = 2'd3;
        end else begin
          error_seen_next = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        // bad continuation byte
        error_seen_next    = 1'b1;
        bytes_pending_next = 2'd0;
      end else begin
        codepoint_accum_next = {codepoint_accum[14:0], b[5:0]};
        bytes_pending_next   = bytes_pending - 2'd1;
        if (bytes_pending == 2'd1 && cp_bad(codepoint_accum_next, sequence_length)) begin
          error_seen_next = 1'b1;
        end
      end
    end
  end

  // one verdict per last-marked word
  assign verdict.fire       = advance && word.is_last;
  assign verdict.name_valid = !error_seen_next && (bytes_pending_next == 2'd0);

  // decoder state, cleared at the end of each name
  always_ff @(posedge clk) begin
    if (rst || (advance && word.is_last)) begin
      error_seen      <= 1'b0;
      bytes_pending   <= 2'd0;
      sequence_length <= 2'd0;
      codepoint_accum <= 21'd0;
      at_name_start   <= 1'b1;
    end else if (advance) begin
      error_seen      <= error_seen_next;
      bytes_pending   <= bytes_pending_next;
      sequence_length <= sequence_length_next;
      codepoint_accum <= codepoint_accum_next;
      at_name_start   <= 1'b0;
    end
  end
endmodule

[src/utf8v_out_stage.sv]
module utf8v_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  utf8v_pkg::verdict_t  verdict,
  output logic                 free,
  utf8v_out_if.source          verdict_out
);
  import utf8v_pkg::*;

  // empty, or the held word leaves this cycle
  assign free = !verdict_out.valid || verdict_out.ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_out.valid <= 1'b0;
    end else if (free) begin
      verdict_out.valid <= verdict.fire;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (free && verdict.fire) begin
      verdict_out.name_valid <= verdict.name_valid;
    end
  end
endmodule

[src/session_name_utf8_validator.sv]
// channel      dir  payload                      handshake
// name_in      in   name_byte[7:0], is_last      valid/ready
// verdict_out  out  name_valid                   valid/ready
//
// one byte per cycle sustained unless a held verdict stalls; a verdict
// passes from its last byte through the input register and the result register
// the decoder state update is the loop that sets that pace
// rst is synchronous and clears both registers and the decoder state
// a held verdict stalls only a following last byte; other bytes keep flowing
module session_name_utf8_validator (
  input  logic         clk,
  input  logic         rst,
  utf8v_in_if.sink     name_in,
  utf8v_out_if.source  verdict_out
);
  import utf8v_pkg::*;

  logic       word_valid;
  name_word_t word;
  logic       advance;
  logic       free;
  verdict_t   verdict;

  // held word moves on unless it needs the result register and that is full
  assign advance = word_valid && (!word.is_last || free);

  utf8v_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .name_in    (name_in),
    .advance    (advance),
    .word_valid (word_valid),
    .word       (word)
  );

  utf8v_decode u_dec (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .word    (word),
    .verdict (verdict)
  );

  utf8v_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .verdict     (verdict),
    .free        (free),
    .verdict_out (verdict_out)
  );
endmodule

[src/utf8v_checker.sv]
module utf8v_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_name_valid
);
  import utf8v_pkg::*;

  // no verdict right after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("verdict valid after reset");

  // input side is open once reset ends
  a_ready_after_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_ready)
    else $error("input not ready after reset");

  // input stalls only behind a stuck verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a held verdict");

  // stalled verdict holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_name_valid)))
    else $error("verdict changed while stalled");
endmodule

bind session_name_utf8_validator utf8v_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (name_in.ready),
  .out_valid      (verdict_out.valid),
  .out_ready      (verdict_out.ready),
  .out_name_valid (verdict_out.name_valid)
);

[sim/testbench.sv]
module testbench;
  import utf8v_pkg::*;

  localparam int unsigned CycleLimit = 300000;
  localparam int unsigned RandomBytes = 1200;
  localparam int unsigned QuietTail = 150;

  // one queued word for the name channel, or a pause until all verdicts are in
  typedef struct packed {
    logic       hold;
    logic       last;
    logic [7:0] b;
  } feed_t;

  logic clk;
  logic rst;

  utf8v_in_if  name_in();
  utf8v_out_if verdict_out();

  session_name_utf8_validator uut (
    .clk        (clk),
    .rst        (rst),
    .name_in    (name_in),
    .verdict_out(verdict_out)
  );

  feed_t       pending_bytes[$];
  logic        expected_verdicts[$];
  logic [7:0]  name_buf[$];

  // predicted decoder state
  logic        name_bad;
  logic [1:0]  cont_left;
  logic [1:0]  seq_cont;
  logic [20:0] cp_acc;
  logic        at_start;

  bit          byte_taken;
  feed_t       cur;
  logic        want;
  int unsigned cycle_count;
  int unsigned send_gap, take_gap;
  int unsigned send_odds, take_odds;
  int unsigned fails, bytes_seen, names_judged, names_ok;

  // banned codepoint ranges: C1 controls, bidi marks, invisibles, tags
  function automatic void ban_range(input int k, output logic [20:0] lo,
                                    output logic [20:0] hi);
    case (k)
      0:       begin lo = CpMin2;     hi = CpC1Hi;      end
      1:       begin lo = CpArabicMk; hi = CpArabicMk;  end
      2:       begin lo = 21'h200E;   hi = 21'h200F;    end
      3:       begin lo = 21'h202A;   hi = CpRloOver;   end
      4:       begin lo = 21'h2066;   hi = 21'h2069;    end
      5:       begin lo = 21'h00AD;   hi = 21'h00AD;    end
      6:       begin lo = 21'h034F;   hi = 21'h034F;    end
      7:       begin lo = 21'h180E;   hi = 21'h180E;    end
      8:       begin lo = 21'h200B;   hi = 21'h200D;    end
      9:       begin lo = 21'h2028;   hi = 21'h2029;    end
      10:      begin lo = 21'h2060;   hi = 21'h2064;    end
      11:      begin lo = 21'hFE00;   hi = 21'hFE0F;    end
      12:      begin lo = CpBom;      hi = CpBom;       end
      13:      begin lo = 21'hFFF9;   hi = 21'hFFFB;    end
      default: begin lo = 21'hE0000;  hi = CpTagHi;     end
    endcase
  endfunction

  function automatic logic cp_banned(input logic [20:0] c);
    logic [20:0] lo, hi;
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < 15; k++) begin
      ban_range(k, lo, hi);
      if (c >= lo && c <= hi) hit = 1'b1;
    end
    return hit;
  endfunction

  // a finished multi-byte codepoint that breaks a rule
  function automatic logic cp_fails(input logic [20:0] c, input logic [1:0] n);
    logic [20:0] floor_cp;
    case (n)
      2'd1:    floor_cp = CpMin2;
      2'd2:    floor_cp = CpMin3;
      default: floor_cp = CpMin4;
    endcase
    return (c < floor_cp) || (c > CpMax) || (c >= CpSurrLo && c <= CpSurrHi) ||
           cp_banned(c);
  endfunction

  function automatic void clear_decoder();
    name_bad  = 1'b0;
    cont_left = 2'd0;
    seq_cont  = 2'd0;
    cp_acc    = '0;
    at_start  = 1'b1;
  endfunction

  // advance the predicted decoder by one accepted word
  function automatic void absorb_byte(input logic [7:0] b, input logic last);
    if (!name_bad) begin
      if (cont_left == 2'd0) begin
        if ((at_start && b == ByteDot) || b == ByteSlash || b < ByteCtrlLimit ||
            b == ByteDel) begin
          name_bad = 1'b1;
        end else if (b[7]) begin
          if (b[7:5] == 3'b110) begin
            cp_acc = {16'd0, b[4:0]};
            seq_cont = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            cp_acc = {17'd0, b[3:0]};
            seq_cont = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            cp_acc = {18'd0, b[2:0]};
            seq_cont = 2'd3;
          end else begin
            name_bad = 1'b1;
          end
          if (!name_bad) cont_left = seq_cont;
        end
      end else if (b[7:6] != 2'b10) begin
        name_bad = 1'b1;
        cont_left = 2'd0;
      end else begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0 && cp_fails(cp_acc, seq_cont)) name_bad = 1'b1;
      end
    end
    at_start = 1'b0;
    if (last) begin
      expected_verdicts.push_back(!name_bad && cont_left == 2'd0);
      clear_decoder();
    end
  endfunction

  // stimulus building
  function automatic void flush_name();
    for (int i = 0; i < name_buf.size(); i++)
      pending_bytes.push_back({1'b0, i == name_buf.size() - 1, name_buf[i]});
    name_buf.delete();
  endfunction

  function automatic void add_hold();
    pending_bytes.push_back({1'b1, 1'b0, 8'h00});
  endfunction

  // n bytes taken from the top of the low n bytes of the word
  function automatic void directed(input logic [31:0] bytes, input int n);
    for (int i = 0; i < n; i++) name_buf.push_back(bytes[8*(n-1-i) +: 8]);
    flush_name();
  endfunction

  function automatic int utf8_len(input logic [20:0] c);
    if (c < CpMin2) return 1;
    if (c < CpMin3) return 2;
    if (c < CpMin4) return 3;
    return 4;
  endfunction

  // encode with a forced length, which may be overlong
  function automatic void put_cp(input logic [20:0] c, input int n);
    case (n)
      1: name_buf.push_back(c[7:0]);
      2: begin
        name_buf.push_back({3'b110, c[10:6]});
        name_buf.push_back({2'b10, c[5:0]});
      end
      3: begin
        name_buf.push_back({4'b1110, c[15:12]});
        name_buf.push_back({2'b10, c[11:6]});
        name_buf.push_back({2'b10, c[5:0]});
      end
      default: begin
        name_buf.push_back({5'b11110, c[20:18]});
        name_buf.push_back({2'b10, c[17:12]});
        name_buf.push_back({2'b10, c[11:6]});
        name_buf.push_back({2'b10, c[5:0]});
      end
    endcase
  endfunction

  // mostly well-formed characters, with every kind of fault mixed in
  function automatic void put_random_char();
    int r, n;
    logic [20:0] c, lo, hi;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      name_buf.push_back(8'($urandom_range(32'h20, 32'h7E)));
    end else if (r < 55) begin
      put_cp(21'($urandom_range(32'h80, 32'h7FF)), 2);
    end else if (r < 70) begin
      put_cp(21'($urandom_range(32'h800, 32'hFFFF)), 3);
    end else if (r < 80) begin
      put_cp(21'($urandom_range(32'h10000, 32'h10FFFF)), 4);
    end else if (r < 86) begin
      ban_range($urandom_range(0, 14), lo, hi);
      case ($urandom_range(0, 3))
        0:       c = lo - 21'd1;
        1:       c = hi + 21'd1;
        default: c = 21'($urandom_range(lo, hi));
      endcase
      put_cp(c, utf8_len(c));
    end else if (r < 89) begin
      n = $urandom_range(2, 4);
      c = 21'($urandom_range(0, n == 2 ? 32'h7F : n == 3 ? 32'h7FF : 32'hFFFF));
      put_cp(c, n);
    end else if (r < 91) begin
      put_cp(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
    end else if (r < 93) begin
      put_cp(21'($urandom_range(32'h10FFFE, 32'h1FFFFF)), 4);
    end else if (r < 96) begin
      name_buf.push_back(8'($urandom_range(0, 255)));
    end else if (r < 98) begin
      // sequence cut short
      n = $urandom_range(2, 4);
      c = 21'($urandom_range(n == 2 ? 32'h80 : n == 3 ? 32'h800 : 32'h10000,
                             n == 2 ? 32'h7FF : n == 3 ? 32'hFFFF : 32'h10FFFF));
      put_cp(c, n);
      repeat ($urandom_range(1, n - 1)) void'(name_buf.pop_back());
    end else begin
      c = 21'($urandom_range(0, 32'h20));
      name_buf.push_back(c == 21'h20 ? ByteDel : c[7:0]);
    end
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // cycle count and idling mood
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 64 == 0) begin
      case ($urandom_range(0, 2))
        0:       send_odds = 0;
        1:       send_odds = 4;
        default: send_odds = 12;
      endcase
      case ($urandom_range(0, 2))
        0:       take_odds = 0;
        1:       take_odds = 3;
        default: take_odds = 10;
      endcase
    end
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // name word driver
  always @(negedge clk) begin
    if (rst) begin
      name_in.valid <= 1'b0;
    end else if (!name_in.valid || byte_taken) begin
      byte_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        name_in.valid <= 1'b0;
      end else if (pending_bytes.size() > 0 && pending_bytes[0].hold) begin
        if (expected_verdicts.size() == 0) void'(pending_bytes.pop_front());
        name_in.valid <= 1'b0;
      end else if (pending_bytes.size() > QuietTail && send_odds != 0 &&
                   $urandom_range(0, send_odds - 1) == 0) begin
        send_gap = $urandom_range(1, 18) - 1;
        name_in.valid <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        cur = pending_bytes.pop_front();
        name_in.valid     <= 1'b1;
        name_in.name_byte <= cur.b;
        name_in.is_last   <= cur.last;
      end else begin
        name_in.valid <= 1'b0;
      end
    end
  end

  // verdict receiver stalls
  always @(negedge clk) begin
    if (rst) begin
      verdict_out.ready <= 1'b0;
    end else if (take_gap > 0) begin
      take_gap--;
      verdict_out.ready <= 1'b0;
    end else if (pending_bytes.size() > QuietTail && take_odds != 0 &&
                 $urandom_range(0, take_odds - 1) == 0) begin
      take_gap = $urandom_range(1, 18) - 1;
      verdict_out.ready <= 1'b0;
    end else begin
      verdict_out.ready <= 1'b1;
    end
  end

  // monitor: predict on each accepted word, check each verdict
  always @(posedge clk) begin
    if (!rst) begin
      if (name_in.valid && name_in.ready) begin
        absorb_byte(name_in.name_byte, name_in.is_last);
        bytes_seen++;
        byte_taken = 1'b1;
      end
      if (verdict_out.valid && verdict_out.ready) begin
        names_judged++;
        if (verdict_out.name_valid) names_ok++;
        if (expected_verdicts.size() == 0) begin
          $error("name_valid: no verdict expected, got %0b", verdict_out.name_valid);
          fails++;
        end else begin
          want = expected_verdicts.pop_front();
          if (verdict_out.name_valid !== want) begin
            $error("name_valid mismatch: expected %0b, got %0b", want,
                   verdict_out.name_valid);
            fails++;
          end
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    rst = 1'b1;
    name_in.valid = 1'b0;
    name_in.name_byte = 8'h00;
    name_in.is_last = 1'b0;
    verdict_out.ready = 1'b0;
    byte_taken = 1'b0;
    cycle_count = 0;
    send_gap = 0;
    take_gap = 0;
    send_odds = 4;
    take_odds = 3;
    fails = 0;
    bytes_seen = 0;
    names_judged = 0;
    names_ok = 0;
    clear_decoder();

    // directed names
    directed(32'h612E, 2);        // dot after the first byte is fine
    directed(32'h2E, 1);          // leading dot
    directed(32'h2F, 1);          // slash
    directed(32'h7F, 1);          // DEL
    directed(32'h00, 1);          // NUL
    directed(32'hFF41, 2);        // bad lead, then a byte that is ignored
    directed(32'hC080, 2);        // overlong
    directed(32'hEDA080, 3);      // surrogate
    directed(32'hF4908080, 4);    // above U+10FFFF
    directed(32'hF48FBFBF, 4);    // U+10FFFF itself
    directed(32'hE2808B, 3);      // zero width space
    directed(32'hE282, 2);        // name ends inside a sequence
    directed(32'hC341, 2);        // bad continuation
    add_hold();

    // random names
    while (pending_bytes.size() < RandomBytes + 30) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 6)) name_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) put_random_char();
      end
      flush_name();
      if ($urandom_range(0, 199) == 0) add_hold();
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || name_in.valid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);

    $display("%0d bytes sent, %0d names judged: %0d accepted, %0d rejected",
             bytes_seen, names_judged, names_ok, names_judged - names_ok);
    $display("names mixed clean text with controls, banned marks, overlong, %s",
             "surrogate, out of range and cut short sequences");
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
